// ===== src/palette_blend_nearest_color_unit_defines.svh =====
// Assertion macros used by the checker file pbn_checker.sv.
// Each macro assumes clk_i is in scope at the point of use; PBN_ASSERT also rst_ni.
`ifndef PALETTE_BLEND_NEAREST_COLOR_UNIT_DEFINES_SVH
`define PALETTE_BLEND_NEAREST_COLOR_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define PBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PBN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/pbn_pkg.sv =====
// Shared types and constants for the palette blend nearest color unit.
// No dependencies.
`timescale 1ns / 1ps

package pbn_pkg;

  localparam int ChanW = 8;            // bits per color channel
  localparam int RgbW = 3 * ChanW;     // packed entry color
  localparam int IdxW = 8;             // external index width
  localparam int PercentW = 7;

  localparam logic [PercentW-1:0] PercentReset = 7'd66;
  localparam logic [PercentW-1:0] PercentMax = 7'd100;

  // Item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  // Tag that follows a palette entry through the error pipeline
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
  } tag_t;

endpackage

// ===== src/pbn_err_unit.sv =====
// Two-stage error pipeline: norm minus dot product of an entry with the blend.
// Depends on pbn_pkg.
`timescale 1ns / 1ps

module pbn_err_unit #(
  parameter int WEIGHT_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pbn_pkg::tag_t                    tag_i,
  input  logic [pbn_pkg::RgbW-1:0]         rgb_i,
  input  logic [WEIGHT_BITS+16:0]          norm_i,
  input  logic [WEIGHT_BITS+7:0]           blend_r_i,
  input  logic [WEIGHT_BITS+7:0]           blend_g_i,
  input  logic [WEIGHT_BITS+7:0]           blend_b_i,
  output pbn_pkg::tag_t                    tag_o,
  output logic signed [WEIGHT_BITS+18:0]   err_o
);

  localparam int NormW = WEIGHT_BITS + 17;
  localparam int ProdW = WEIGHT_BITS + 16;
  localparam int DotW = WEIGHT_BITS + 18;
  localparam int ErrW = WEIGHT_BITS + 19;
  localparam int CW = pbn_pkg::ChanW;

  pbn_pkg::tag_t             tag1_q, tag2_q;
  logic [ProdW-1:0]          prod_r_q, prod_g_q, prod_b_q;
  logic [NormW-1:0]          norm1_q;
  logic [DotW-1:0]           dot;
  logic signed [ErrW-1:0]    err_d, err_q;

  // Stage 1: one product per channel
  always_ff @(posedge clk_i) begin
    prod_r_q <= ProdW'(rgb_i[3*CW-1:2*CW]) * ProdW'(blend_r_i);
    prod_g_q <= ProdW'(rgb_i[2*CW-1:CW]) * ProdW'(blend_g_i);
    prod_b_q <= ProdW'(rgb_i[CW-1:0]) * ProdW'(blend_b_i);
    norm1_q  <= norm_i;
  end

  // Stage 2: sum and subtract
  assign dot = DotW'(prod_r_q) + DotW'(prod_g_q) + DotW'(prod_b_q);
  assign err_d = $signed(ErrW'(norm1_q)) - $signed(ErrW'(dot));

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  assign tag_o = tag2_q;
  assign err_o = err_q;

endmodule

// ===== src/palette_blend_nearest_color_unit.sv =====
// Top level of the palette blend nearest color unit: palette memory, sequencer
// and search compare. Depends on pbn_pkg and pbn_err_unit.
`timescale 1ns / 1ps

// Nearest palette color for a two-color blend. A write item (kind 0) stores
// one RGB entry and its scaled squared norm in a synchronous palette memory
// with one write and one read port; busy_o stays low. A query item
// (kind 1) reads the background and foreground colors, blends them with
// weights set by filter_percent (saturated at 100), then reads every palette
// entry one per cycle, highest index first, and keeps the entry with the
// least norm minus dot product; ties go to the higher index. busy_o is high
// from the cycle after a query is accepted until its result. The result
// appears on best_index_o with valid_o high for exactly one cycle, in the
// first cycle that busy_o is low again; there is no back-pressure on the
// result side, so a result must be taken in that cycle. A new item may be
// accepted in that same cycle. Every palette entry must be written before the
// first query; entries that were never written read as unknown. The user
// must write filter_percent_i only while busy_o is low; the block itself
// does not enforce this.
module palette_blend_nearest_color_unit #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int WEIGHT_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item channel
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              kind_i,
  input  logic [pbn_pkg::IdxW-1:0]          background_index_i,
  input  logic [pbn_pkg::IdxW-1:0]          foreground_index_i,
  input  logic [pbn_pkg::ChanW-1:0]         red_i,
  input  logic [pbn_pkg::ChanW-1:0]         green_i,
  input  logic [pbn_pkg::ChanW-1:0]         blue_i,
  // configuration
  input  logic                              filter_percent_we_i,
  input  logic [pbn_pkg::PercentW-1:0]      filter_percent_i,
  // result
  output logic                              valid_o,
  output logic [pbn_pkg::IdxW-1:0]          best_index_o
);

  localparam int AddrW = $clog2(PALETTE_ENTRIES);
  localparam int WgtW = WEIGHT_BITS + 1;      // weight up to 2^WEIGHT_BITS
  localparam int ChW = WEIGHT_BITS + 8;       // blended channel
  localparam int NormW = WEIGHT_BITS + 17;
  localparam int ErrW = WEIGHT_BITS + 19;
  localparam int CW = pbn_pkg::ChanW;
  localparam int RgbW = pbn_pkg::RgbW;
  localparam int MemW = NormW + RgbW;
  localparam int NumTab = 101;                // percent 0..100

  localparam logic [pbn_pkg::IdxW:0]   NumEntries = (pbn_pkg::IdxW + 1)'(PALETTE_ENTRIES);
  localparam logic [AddrW-1:0]         LastAddr = AddrW'(PALETTE_ENTRIES - 1);
  localparam logic [WgtW-1:0]          WgtOne = WgtW'(1 << WEIGHT_BITS);
  localparam logic signed [ErrW-1:0]   ErrMax = {1'b0, {(ErrW-1){1'b1}}};

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFg    = 3'd1;  // background data back, read foreground
  localparam logic [2:0] StBlend = 3'd2;  // foreground data back, form blend
  localparam logic [2:0] StScan  = 3'd3;  // one palette read per cycle
  localparam logic [2:0] StDrain = 3'd4;  // wait for the last compare

  logic [2:0]                     state_q, state_d;
  logic [pbn_pkg::PercentW-1:0]   pct_q, pct_sat;

  // Foreground weight per percent, worked out at elaboration
  logic [WgtW-1:0] w1_tab [NumTab];
  for (genvar g = 0; g < NumTab; g++) begin : g_wtab
    localparam int W1 = (g << WEIGHT_BITS) / pbn_pkg::PercentMax;
    assign w1_tab[g] = WgtW'(W1);
  end

  // Palette memory: {norm, rgb}
  logic [MemW-1:0]   pal_mem_q [PALETTE_ENTRIES];
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [MemW-1:0]   mem_wdata, rd_data_q;

  logic                    accept, wr_in_range, bg_in_range, fg_in_range;
  logic [17:0]             sumsq;
  logic [NormW-1:0]        norm_wr;
  logic [WgtW-1:0]         w1_q, w2_q, w1_sel;
  logic [AddrW-1:0]        fg_addr_q, cnt_q;
  logic                    fg_black_q, rd_black_q;
  logic [RgbW-1:0]         rd_rgb;
  logic [ChW-1:0]          bgp_r_q, bgp_g_q, bgp_b_q;
  logic [ChW-1:0]          blend_r_q, blend_g_q, blend_b_q;
  pbn_pkg::tag_t           rd_tag_q, err_tag;
  logic signed [ErrW-1:0]  err, best_q;
  logic [pbn_pkg::IdxW-1:0] best_idx_q, best_idx_new;
  logic                    take, last;
  logic                    valid_q;
  logic [pbn_pkg::IdxW-1:0] best_index_q;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  assign wr_in_range = ({1'b0, background_index_i} < NumEntries);
  assign bg_in_range = wr_in_range;
  assign fg_in_range = ({1'b0, foreground_index_i} < NumEntries);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= pbn_pkg::PercentReset;
    end else if (filter_percent_we_i) begin
      pct_q <= filter_percent_i;
    end
  end

  assign pct_sat = (pct_q > pbn_pkg::PercentMax) ? pbn_pkg::PercentMax : pct_q;
  assign w1_sel = w1_tab[pct_sat];

  // Write path: squared norm scaled by half the weight range
  assign sumsq = 18'(red_i) * 18'(red_i) + 18'(green_i) * 18'(green_i)
               + 18'(blue_i) * 18'(blue_i);
  assign norm_wr = NormW'(sumsq) << (WEIGHT_BITS - 1);

  assign mem_we = accept && (kind_i == pbn_pkg::KindWrite) && wr_in_range;
  assign mem_waddr = background_index_i[AddrW-1:0];
  assign mem_wdata = {norm_wr, red_i, green_i, blue_i};

  // Reads and writes never share a cycle: writes land only in idle, reads
  // only as a query is accepted or runs, so no forwarding is needed.
  always_comb begin
    mem_re = 1'b0;
    mem_raddr = cnt_q;
    unique case (state_q)
      StIdle: begin
        mem_re = accept && (kind_i == pbn_pkg::KindQuery);
        mem_raddr = background_index_i[AddrW-1:0];
      end
      StFg: begin
        mem_re = 1'b1;
        mem_raddr = fg_addr_q;
      end
      StScan: begin
        mem_re = 1'b1;
        mem_raddr = cnt_q;
      end
      StBlend, StDrain: begin
        mem_re = 1'b0;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pal_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= pal_mem_q[mem_raddr];
    end
  end

  // An index beyond the palette reads as black
  assign rd_rgb = rd_black_q ? '0 : rd_data_q[RgbW-1:0];

  // Query datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      w1_q       <= w1_sel;
      w2_q       <= WgtOne - w1_sel;
      fg_addr_q  <= foreground_index_i[AddrW-1:0];
      fg_black_q <= !fg_in_range;
      rd_black_q <= !bg_in_range;
    end
    if (state_q == StFg) begin
      bgp_r_q    <= ChW'(rd_rgb[3*CW-1:2*CW]) * ChW'(w2_q);
      bgp_g_q    <= ChW'(rd_rgb[2*CW-1:CW]) * ChW'(w2_q);
      bgp_b_q    <= ChW'(rd_rgb[CW-1:0]) * ChW'(w2_q);
      rd_black_q <= fg_black_q;
    end
    if (state_q == StBlend) begin
      blend_r_q  <= bgp_r_q + ChW'(rd_rgb[3*CW-1:2*CW]) * ChW'(w1_q);
      blend_g_q  <= bgp_g_q + ChW'(rd_rgb[2*CW-1:CW]) * ChW'(w1_q);
      blend_b_q  <= bgp_b_q + ChW'(rd_rgb[CW-1:0]) * ChW'(w1_q);
      rd_black_q <= 1'b0;
    end
  end

  // Scan counter, highest index first
  always_ff @(posedge clk_i) begin
    if (state_q == StBlend) begin
      cnt_q <= LastAddr;
    end else if (state_q == StScan) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && (kind_i == pbn_pkg::KindQuery)) state_d = StFg;
      end
      StFg:    state_d = StBlend;
      StBlend: state_d = StScan;
      StScan: begin
        if (cnt_q == '0) state_d = StDrain;
      end
      StDrain: begin
        if (last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_tag_q <= '0;
    end else begin
      state_q        <= state_d;
      rd_tag_q.valid <= (state_q == StScan);
      rd_tag_q.idx   <= pbn_pkg::IdxW'(cnt_q);
    end
  end

  pbn_err_unit #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_err (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (rd_tag_q),
    .rgb_i     (rd_data_q[RgbW-1:0]),
    .norm_i    (rd_data_q[MemW-1:RgbW]),
    .blend_r_i (blend_r_q),
    .blend_g_i (blend_g_q),
    .blend_b_i (blend_b_q),
    .tag_o     (err_tag),
    .err_o     (err)
  );

  // Strict less-than with descending scan: ties keep the higher index
  assign take = err_tag.valid && (err < best_q);
  assign last = err_tag.valid && (err_tag.idx == '0);
  assign best_idx_new = take ? err_tag.idx : best_idx_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_q <= ErrMax;
    end else if (take) begin
      best_q     <= err;
      best_idx_q <= err_tag.idx;
    end
    if (last) begin
      best_index_q <= best_idx_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= last;
    end
  end

  assign valid_o = valid_q;
  assign best_index_o = best_index_q;

endmodule

// ===== src/pbn_checker.sv =====
// Port-level checker for the palette blend nearest color unit, with its bind.
// Depends on pbn_pkg and palette_blend_nearest_color_unit_defines.svh.
`timescale 1ns / 1ps
`include "palette_blend_nearest_color_unit_defines.svh"

module pbn_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic kind_i,
  input logic busy_o,
  input logic valid_o
);

  // A query item keeps the block busy in the next cycle
  `PBN_ASSERT(a_query_busy, start_i && !busy_o && (kind_i == pbn_pkg::KindQuery) |=> busy_o, "query item did not raise busy")

  // A write item finishes at once and makes no result
  `PBN_ASSERT(a_write_quiet, start_i && !busy_o && (kind_i == pbn_pkg::KindWrite) |=> !busy_o && !valid_o, "write item raised busy or a result")

  // Busy ends only together with a result
  `PBN_ASSERT(a_busy_end, $fell(busy_o) |-> valid_o, "busy fell without a result")

  // Results are single-cycle and never while busy
  `PBN_ASSERT(a_result_idle, valid_o |-> !busy_o ##1 !valid_o, "result overlapped busy or lasted two cycles")

endmodule

bind palette_blend_nearest_color_unit pbn_checker u_pbn_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .kind_i  (kind_i),
  .busy_o  (busy_o),
  .valid_o (valid_o)
);
